// File: rtl/prtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prtt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int ID_BITS     = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [ID_BITS-1:0] id_t;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_CANCEL   = 2'd2,
        OP_EXPIRE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CREATED     = 3'd0,
        ST_COMPLETED   = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_CANCELED    = 3'd3,
        ST_TIMED_OUT   = 3'd4,
        ST_EXPIRE_DONE = 3'd5,
        ST_TABLE_FULL  = 3'd6
    } status_t;

    // one table entry as held in memory
    typedef struct packed {
        id_t         id;
        logic [31:0] tag;
        logic        has_dl;
        logic [31:0] deadline;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // 32-bit port value to id width (zero extend or truncate)
    function automatic id_t to_id(logic [31:0] v);
        logic [ID_BITS+31:0] w;
        w = {{ID_BITS{1'b0}}, v};
        return w[ID_BITS-1:0];
    endfunction

    // id back to the 32-bit port width
    function automatic logic [31:0] from_id(id_t v);
        logic [ID_BITS+31:0] w;
        w = {32'd0, v};
        return w[31:0];
    endfunction

    // count to the 5-bit port width
    function automatic logic [4:0] cnt_to_port(logic [CNT_W-1:0] v);
        logic [CNT_W+4:0] w;
        w = {5'd0, v};
        return w[4:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/prtt_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prtt_req_if;
    import prtt_pkg::*;

    logic        valid;
    logic        ready;
    op_t         opcode;
    logic [31:0] req_id;
    logic [31:0] timeout_ticks;
    logic [31:0] cont_tag;
    logic [31:0] now_time;

    modport source (
        output valid, opcode, req_id, timeout_ticks, cont_tag, now_time,
        input  ready
    );

    modport sink (
        input  valid, opcode, req_id, timeout_ticks, cont_tag, now_time,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/prtt_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prtt_rsp_if;
    import prtt_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    logic [31:0] resp_id;
    logic [31:0] resp_tag;
    logic [4:0]  expired_count;
    logic [4:0]  occupancy;
    logic        last;

    modport source (
        output valid, status, resp_id, resp_tag, expired_count, occupancy, last,
        input  ready
    );

    modport sink (
        input  valid, status, resp_id, resp_tag, expired_count, occupancy, last,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/pending_request_table_with_timeout_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake     Payload
// req       in   valid/ready   opcode, req_id, timeout_ticks, cont_tag, now_time
// rsp       out  valid/ready   status, resp_id, resp_tag, expired_count,
//                              occupancy, last
//
// Complete and cancel walk the entry RAM one entry per cycle. An expire scan
// walks all entries once, then reads back each expired entry for its
// timed_out result and ends with the expire_done result. The entry RAM has
// a single read port, so the walks read one entry at a time.
// Reset clears all valid bits and sets the id counter to one; no RAM sweep.
// A stalled rsp holds the sequencer before its next result; the last result
// of a request sits in the output register while the next request is taken.

module pending_request_table_with_timeout_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    prtt_req_if.sink   req,
    prtt_rsp_if.source rsp
);
    import prtt_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_WALK,     // issue reads, check previous entry
        S_DRAIN,    // check the final entry
        S_EMIT_RD,  // read next expired entry
        S_EMIT_DAT, // build its timed_out result
        S_PUT       // hand staged result to the output register
    } state_t;

    // lowest set bit of a vector
    function automatic logic [IDX_W-1:0] low_set(logic [TABLE_DEPTH-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    state_t                 after_reg, after_next;
    op_t                    op_reg, op_next;
    id_t                    rid_reg, rid_next;
    logic [31:0]            tmo_reg, tmo_next;
    logic [31:0]            tag_reg, tag_next;
    logic [31:0]            now_reg, now_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       occ_reg, occ_next;
    id_t                    id_cnt_reg, id_cnt_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic                   chk_reg, chk_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic [TABLE_DEPTH-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // staged result
    status_t                res_status_reg, res_status_next;
    logic [31:0]            res_id_reg, res_id_next;
    logic [31:0]            res_tag_reg, res_tag_next;
    logic [CNT_W-1:0]       res_cnt_reg, res_cnt_next;
    logic                   res_last_reg, res_last_next;

    // output register
    logic                   out_vld_reg, out_vld_next;
    status_t                out_status_reg, out_status_next;
    logic [31:0]            out_id_reg, out_id_next;
    logic [31:0]            out_tag_reg, out_tag_next;
    logic [4:0]             out_cnt_reg, out_cnt_next;
    logic [4:0]             out_occ_reg, out_occ_next;
    logic                   out_last_reg, out_last_next;

    // entry RAM
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]     mem_rdata;
    entry_t                 rd_ent;

    logic [IDX_W-1:0]       free_idx;
    logic                   out_free;
    logic                   hit_id;
    logic                   hit_exp;
    id_t                    id_nxt;
    id_t                    id_use;
    logic [32:0]            dl_sum;

    prtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_ent   = entry_t'(mem_rdata);
    assign free_idx = low_set(~valid_reg);
    assign out_free = !out_vld_reg || rsp.ready;

    // entry checks on the word read in the previous cycle
    assign hit_id  = valid_reg[chk_idx_reg] && (rd_ent.id == rid_reg);
    assign hit_exp = valid_reg[chk_idx_reg] && rd_ent.has_dl &&
                     (rd_ent.deadline <= now_reg);

    // next id, zero is skipped
    assign id_nxt = id_cnt_reg + id_t'(1);
    assign id_use = (id_cnt_reg == '0) ? id_nxt : id_cnt_reg;

    // deadline = now + timeout, saturating
    assign dl_sum = {1'b0, now_reg} + {1'b0, tmo_reg};

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_vld_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.resp_id       = out_id_reg;
    assign rsp.resp_tag      = out_tag_reg;
    assign rsp.expired_count = out_cnt_reg;
    assign rsp.occupancy     = out_occ_reg;
    assign rsp.last          = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        op_next         = op_reg;
        rid_next        = rid_reg;
        tmo_next        = tmo_reg;
        tag_next        = tag_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        occ_next        = occ_reg;
        id_cnt_next     = id_cnt_reg;
        ptr_next        = ptr_reg;
        chk_next        = chk_reg;
        chk_idx_next    = chk_idx_reg;
        mask_next       = mask_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_tag_next    = res_tag_reg;
        res_cnt_next    = res_cnt_reg;
        res_last_next   = res_last_reg;
        out_vld_next    = out_vld_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_tag_next    = out_tag_reg;
        out_cnt_next    = out_cnt_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;

        mem_we             = 1'b0;
        mem_waddr          = free_idx;
        mem_wdata.id       = id_use;
        mem_wdata.tag      = tag_reg;
        mem_wdata.has_dl   = (tmo_reg != '0);
        mem_wdata.deadline = (tmo_reg == '0) ? 32'd0 :
                             (dl_sum[32] ? '1 : dl_sum[31:0]);
        mem_re             = 1'b0;
        mem_raddr          = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = req.opcode;
                    rid_next  = to_id(req.req_id);
                    tmo_next  = req.timeout_ticks;
                    tag_next  = req.cont_tag;
                    now_next  = req.now_time;
                    ptr_next  = '0;
                    chk_next  = 1'b0;
                    mask_next = '0;
                    cnt_next  = '0;
                    if (req.opcode == OP_CREATE)
                    begin
                        state_next = S_CREATE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end

            S_CREATE:
            begin
                res_cnt_next  = '0;
                res_last_next = 1'b1;
                after_next    = S_IDLE;
                state_next    = S_PUT;
                if (&valid_reg)
                begin
                    res_status_next = ST_TABLE_FULL;
                    res_id_next     = '0;
                    res_tag_next    = '0;
                end
                else
                begin
                    mem_we               = 1'b1;
                    valid_next[free_idx] = 1'b1;
                    occ_next             = occ_reg + CNT_W'(1);
                    id_cnt_next          = (id_cnt_reg == '0) ? id_nxt + id_t'(1) : id_nxt;
                    res_status_next      = ST_CREATED;
                    res_id_next          = from_id(id_use);
                    res_tag_next         = tag_reg;
                end
            end

            S_WALK, S_DRAIN:
            begin
                chk_next = 1'b0;
                if (state_reg == S_WALK)
                begin
                    mem_re       = 1'b1;
                    chk_next     = 1'b1;
                    chk_idx_next = ptr_reg;
                    if (ptr_reg == LAST_IDX)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end

                if (op_reg == OP_EXPIRE)
                begin
                    if (chk_reg && hit_exp)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        mask_next[chk_idx_reg]  = 1'b1;
                        occ_next                = occ_reg - CNT_W'(1);
                        cnt_next                = cnt_reg + CNT_W'(1);
                    end
                    if (state_reg == S_DRAIN)
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
                else
                begin
                    res_cnt_next  = '0;
                    res_last_next = 1'b1;
                    res_id_next   = from_id(rid_reg);
                    if (chk_reg && hit_id)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        occ_next                = occ_reg - CNT_W'(1);
                        chk_next                = 1'b0;
                        after_next              = S_IDLE;
                        state_next              = S_PUT;
                        if (op_reg == OP_COMPLETE)
                        begin
                            res_status_next = ST_COMPLETED;
                            res_tag_next    = (tag_reg != '0) ? tag_reg : rd_ent.tag;
                        end
                        else
                        begin
                            res_status_next = ST_CANCELED;
                            res_tag_next    = rd_ent.tag;
                        end
                    end
                    else if (state_reg == S_DRAIN)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        res_tag_next    = '0;
                        after_next      = S_IDLE;
                        state_next      = S_PUT;
                    end
                end
            end

            S_EMIT_RD:
            begin
                if (mask_reg == '0)
                begin
                    res_status_next = ST_EXPIRE_DONE;
                    res_id_next     = '0;
                    res_tag_next    = '0;
                    res_cnt_next    = cnt_reg;
                    res_last_next   = 1'b1;
                    after_next      = S_IDLE;
                    state_next      = S_PUT;
                end
                else
                begin
                    mem_re                       = 1'b1;
                    mem_raddr                    = low_set(mask_reg);
                    mask_next[low_set(mask_reg)] = 1'b0;
                    state_next                   = S_EMIT_DAT;
                end
            end

            S_EMIT_DAT:
            begin
                res_status_next = ST_TIMED_OUT;
                res_id_next     = from_id(rd_ent.id);
                res_tag_next    = rd_ent.tag;
                res_cnt_next    = '0;
                res_last_next   = 1'b0;
                after_next      = S_EMIT_RD;
                state_next      = S_PUT;
            end

            S_PUT:
            begin
                // occupancy is final by the time any result gets here
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_tag_next    = res_tag_reg;
                    out_cnt_next    = cnt_to_port(res_cnt_reg);
                    out_occ_next    = cnt_to_port(occ_reg);
                    out_last_next   = res_last_reg;
                    state_next      = after_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            after_reg      <= S_IDLE;
            op_reg         <= OP_CREATE;
            rid_reg        <= '0;
            tmo_reg        <= '0;
            tag_reg        <= '0;
            now_reg        <= '0;
            valid_reg      <= '0;
            occ_reg        <= '0;
            id_cnt_reg     <= id_t'(1);
            ptr_reg        <= '0;
            chk_reg        <= 1'b0;
            chk_idx_reg    <= '0;
            mask_reg       <= '0;
            cnt_reg        <= '0;
            res_status_reg <= ST_CREATED;
            res_id_reg     <= '0;
            res_tag_reg    <= '0;
            res_cnt_reg    <= '0;
            res_last_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
            out_status_reg <= ST_CREATED;
            out_id_reg     <= '0;
            out_tag_reg    <= '0;
            out_cnt_reg    <= '0;
            out_occ_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            after_reg      <= after_next;
            op_reg         <= op_next;
            rid_reg        <= rid_next;
            tmo_reg        <= tmo_next;
            tag_reg        <= tag_next;
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            occ_reg        <= occ_next;
            id_cnt_reg     <= id_cnt_next;
            ptr_reg        <= ptr_next;
            chk_reg        <= chk_next;
            chk_idx_reg    <= chk_idx_next;
            mask_reg       <= mask_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_tag_reg    <= res_tag_next;
            res_cnt_reg    <= res_cnt_next;
            res_last_reg   <= res_last_next;
            out_vld_reg    <= out_vld_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_tag_reg    <= out_tag_next;
            out_cnt_reg    <= out_cnt_next;
            out_occ_reg    <= out_occ_next;
            out_last_reg   <= out_last_next;
        end
    end

`ifndef ASSERT_OFF
    // occupancy counter tracks the valid bits
    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == CNT_W'($countones(valid_reg)))
        else $error("occupancy counter out of step with valid bits");

    // only timed_out results leave the request open
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.last == (rsp.status != ST_TIMED_OUT)))
        else $error("last flag does not match status");

    // expired count only on expire_done
    a_cnt_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_EXPIRE_DONE) |-> (rsp.expired_count == 5'd0))
        else $error("expired_count set outside expire_done");

    // created ids are never zero
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_CREATED) |-> (rsp.resp_id != 32'd0))
        else $error("zero id handed out");

    // an accepted request always starts work
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

// File: rtl/prtt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// simple dual-port RAM, one write and one registered read
module prtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: tb/prtt_table_checker.sv
`timescale 1ns / 1ps

module prtt_table_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    prtt_req_if       req,
    prtt_rsp_if       rsp,
    output int        fail_count,
    output int        pending_rsp,
    output int        rsp_checked,
    output int        timeouts_seen,
    output int        full_seen
);
    import prtt_pkg::*;

    typedef struct {
        status_t     status;
        logic [31:0] id;
        logic [31:0] tag;
        logic [4:0]  xcount;
        logic [4:0]  occ;
        logic        last;
    } rsp_fields_t;

    // shadow of the outstanding request table
    logic        slot_live  [TABLE_DEPTH];
    id_t         slot_rid   [TABLE_DEPTH];
    logic [31:0] slot_ctag  [TABLE_DEPTH];
    logic        slot_timed [TABLE_DEPTH];
    logic [31:0] slot_dline [TABLE_DEPTH];
    id_t         id_next;

    rsp_fields_t rsp_expected [$];

    function automatic logic [4:0] live_entries();
        int i;
        int n;
        n = 0;
        for (i = 0; i < TABLE_DEPTH; i++)
            if (slot_live[i])
                n++;
        return 5'(n);
    endfunction

    function automatic void queue_rsp(status_t s, logic [31:0] id, logic [31:0] tag,
                                      logic [4:0] cnt, logic [4:0] occ, logic lst);
        rsp_fields_t r;
        r.status = s;
        r.id     = id;
        r.tag    = tag;
        r.xcount = cnt;
        r.occ    = occ;
        r.last   = lst;
        rsp_expected.push_back(r);
    endfunction

    function automatic int field_bad(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
            return 0;
        $error("%s: expected %0h, got %0h", name, want, got);
        return 1;
    endfunction

    // one table operation; appends the responses it causes
    task automatic apply_request(input op_t op, input logic [31:0] rid_in,
                                 input logic [31:0] tmo, input logic [31:0] tag,
                                 input logic [31:0] now);
        int          i;
        int          slot;
        int          n_exp;
        id_t         rid;
        id_t         nid;
        logic [32:0] sum;
        logic        hit [TABLE_DEPTH];
        logic [4:0]  occ;
        rid = id_t'(rid_in);
        case (op)
            OP_CREATE:
            begin
                slot = -1;
                for (i = TABLE_DEPTH - 1; i >= 0; i--)
                    if (!slot_live[i])
                        slot = i;
                if (slot < 0)
                begin
                    queue_rsp(ST_TABLE_FULL, '0, '0, '0, live_entries(), 1'b1);
                end
                else
                begin
                    nid     = id_next;
                    id_next = id_next + id_t'(1);
                    if (nid == '0)
                    begin
                        nid     = id_next;
                        id_next = id_next + id_t'(1);
                    end
                    sum               = {1'b0, now} + {1'b0, tmo};
                    slot_live[slot]   = 1'b1;
                    slot_rid[slot]    = nid;
                    slot_ctag[slot]   = tag;
                    slot_timed[slot]  = (tmo != '0);
                    slot_dline[slot]  = (tmo == '0) ? '0 : (sum[32] ? '1 : sum[31:0]);
                    queue_rsp(ST_CREATED, 32'(nid), tag, '0, live_entries(), 1'b1);
                end
            end
            OP_COMPLETE, OP_CANCEL:
            begin
                slot = -1;
                for (i = TABLE_DEPTH - 1; i >= 0; i--)
                    if (slot_live[i] && slot_rid[i] == rid)
                        slot = i;
                if (slot < 0)
                begin
                    queue_rsp(ST_NOT_FOUND, 32'(rid), '0, '0, live_entries(), 1'b1);
                end
                else
                begin
                    slot_live[slot] = 1'b0;
                    if (op == OP_COMPLETE)
                        queue_rsp(ST_COMPLETED, 32'(rid), (tag != '0) ? tag : slot_ctag[slot],
                                  '0, live_entries(), 1'b1);
                    else
                        queue_rsp(ST_CANCELED, 32'(rid), slot_ctag[slot], '0,
                                  live_entries(), 1'b1);
                end
            end
            default:
            begin
                n_exp = 0;
                for (i = 0; i < TABLE_DEPTH; i++)
                begin
                    hit[i] = slot_live[i] && slot_timed[i] && (slot_dline[i] <= now);
                    if (hit[i])
                    begin
                        slot_live[i] = 1'b0;
                        n_exp++;
                    end
                end
                occ = live_entries();
                for (i = 0; i < TABLE_DEPTH; i++)
                    if (hit[i])
                        queue_rsp(ST_TIMED_OUT, 32'(slot_rid[i]), slot_ctag[i], '0, occ, 1'b0);
                queue_rsp(ST_EXPIRE_DONE, '0, '0, 5'(n_exp), occ, 1'b1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        rsp_fields_t want;
        int          i;
        int          bad;
        if (!rst_n)
        begin
            for (i = 0; i < TABLE_DEPTH; i++)
                slot_live[i] = 1'b0;
            id_next = id_t'(1);
            rsp_expected.delete();
            fail_count    = 0;
            pending_rsp   = 0;
            rsp_checked   = 0;
            timeouts_seen = 0;
            full_seen     = 0;
        end
        else
        begin
            // response first: it can only stem from an earlier request
            if (rsp.valid && rsp.ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $error("response with nothing outstanding: status %0d id %0h",
                           rsp.status, rsp.resp_id);
                    fail_count++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    bad  = field_bad("status", 32'(want.status), 32'(rsp.status))
                         + field_bad("resp_id", want.id, rsp.resp_id)
                         + field_bad("resp_tag", want.tag, rsp.resp_tag)
                         + field_bad("expired_count", 32'(want.xcount), 32'(rsp.expired_count))
                         + field_bad("occupancy", 32'(want.occ), 32'(rsp.occupancy))
                         + field_bad("last", 32'(want.last), 32'(rsp.last));
                    if (bad != 0)
                        fail_count++;
                    if (want.status == ST_TIMED_OUT)
                        timeouts_seen++;
                    if (want.status == ST_TABLE_FULL)
                        full_seen++;
                end
                rsp_checked++;
            end
            if (req.valid && req.ready)
                apply_request(req.opcode, req.req_id, req.timeout_ticks, req.cont_tag,
                              req.now_time);
            pending_rsp = rsp_expected.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// Testbench top: makes request traffic and response back-pressure, and gives
// the verdict. All prediction and comparison lives in prtt_table_checker.
module tb;
    import prtt_pkg::*;

    localparam int RAND_EPOCHS     = 8;     // random part, in time epochs
    localparam int EPOCH_REQS      = 50;    // requests per epoch
    localparam int RSP_HOLD_CYCLES = 400;   // long response hold-off
    localparam int STALL_LIMIT     = 3000;  // cycles without any handshake
    localparam int DRAIN_CYCLES    = 80;    // quiet time after last response

    logic clk;
    logic rst_n;

    int fail_count;
    int pending_rsp;
    int rsp_checked;
    int timeouts_seen;
    int full_seen;

    logic [31:0] tick_now;      // now_time sent with every request, never goes back
    bit          no_idle;       // both sides run without gaps
    bit          hold_rsp;      // ask the response side for one long hold-off
    int          sent_count;
    logic [31:0] live_ids [$];  // ids seen created and not yet freed

    prtt_req_if req_ch ();
    prtt_rsp_if rsp_ch ();

    pending_request_table_with_timeout_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    prtt_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .fail_count    (fail_count),
        .pending_rsp   (pending_rsp),
        .rsp_checked   (rsp_checked),
        .timeouts_seen (timeouts_seen),
        .full_seen     (full_seen)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Offer one request and hold it until accepted. Called at a rising edge;
    // returns at the edge where the request was taken, valid still high.
    task automatic issue_request(input op_t op, input logic [31:0] rid,
                                 input logic [31:0] tmo, input logic [31:0] tag);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.opcode        <= op;
        req_ch.req_id        <= rid;
        req_ch.timeout_ticks <= tmo;
        req_ch.cont_tag      <= tag;
        req_ch.now_time      <= tick_now;
        req_ch.valid         <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_count++;
    endtask

    // Response side: a random gap before each response, plus one long
    // hold-off on request so the table backs up into the request channel.
    initial
    begin : rsp_sink
        int gap;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 3);
            if (gap != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    // Keep a pool of live ids for well-formed complete/cancel traffic.
    // Sampled mid-cycle, so it never races the stimulus at the rising edge.
    always @(negedge clk)
    begin : track_live_ids
        int i;
        int found;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_ch.status == ST_CREATED)
            begin
                live_ids.push_back(rsp_ch.resp_id);
            end
            else if (rsp_ch.status == ST_TIMED_OUT)
            begin
                found = -1;
                for (i = 0; i < live_ids.size(); i++)
                    if (found < 0 && live_ids[i] == rsp_ch.resp_id)
                        found = i;
                if (found >= 0)
                    live_ids.delete(found);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin : stall_watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d responses still due",
                 STALL_LIMIT, pending_rsp);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int          i;
        int          e;
        int          n;
        int          pct;
        int          sel;
        int          create_pct;
        int          k;
        logic [31:0] base;
        logic [32:0] step;
        logic [31:0] tmo;
        logic [31:0] tag;
        logic [31:0] id;

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.opcode        <= OP_CREATE;
        req_ch.req_id        <= '0;
        req_ch.timeout_ticks <= '0;
        req_ch.cont_tag      <= '0;
        req_ch.now_time      <= '0;
        tick_now   = '0;
        no_idle    = 1'b0;
        hold_rsp   = 1'b0;
        sent_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // empty table: scan with nothing to expire, lookups that miss
        issue_request(OP_EXPIRE, '0, '0, '0);
        issue_request(OP_COMPLETE, '0, '0, '0);
        issue_request(OP_CANCEL, '1, '1, '1);

        // fill every slot; ids come out 1..16. Mix of no deadline, short
        // deadlines and one that saturates at all ones.
        tick_now = 32'd10;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            if (i == TABLE_DEPTH - 1)
                tmo = '1;
            else if (i % 4 == 0)
                tmo = '0;
            else
                tmo = 32'(2 * i);
            if (i == 0)
                tag = '1;
            else if (i == 1)
                tag = '0;
            else
                tag = $urandom();
            issue_request(OP_CREATE, $urandom(), tmo, tag);
        end
        // one more create is refused, counter must not move
        issue_request(OP_CREATE, '0, 32'd7, 32'h1234_5678);

        tick_now = 32'd12;
        // zero response tag returns the stored tag; nonzero one passes through
        issue_request(OP_COMPLETE, 32'd1, '0, '0);
        issue_request(OP_COMPLETE, 32'd2, '0, 32'h5A5A_5A5A);
        issue_request(OP_CANCEL, 32'd3, '0, '0);

        // slots with deadline <= 20 that are still live go out as timeouts
        tick_now = 32'd20;
        issue_request(OP_EXPIRE, '1, '1, '1);

        // ---- random part ----
        // Time moves forward in epochs that climb through the 32-bit range;
        // the last one sits just under all ones, where deadlines saturate.
        for (e = 0; e < RAND_EPOCHS; e++)
        begin
            if (e == RAND_EPOCHS - 1)
                base = 32'hFFFF_F000 + $urandom_range(0, 255);
            else
                base = (32'(e) << 29) + $urandom_range(0, 32'h0FFF_FFFF);
            if (base > tick_now)
                tick_now = base;
            no_idle = (e == 3);         // one epoch of back-to-back traffic
            if (e == 2)
                hold_rsp = 1'b1;        // receiver stalls, table backs up
            create_pct = (e % 2 == 0) ? 55 : 30;

            for (n = 0; n < EPOCH_REQS; n++)
            begin
                step     = {1'b0, tick_now} + 33'($urandom_range(0, 12));
                tick_now = step[32] ? '1 : step[31:0];
                pct      = $urandom_range(0, 99);
                if (pct < create_pct)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel < 3)
                        tmo = '0;
                    else if (sel < 8)
                        tmo = $urandom_range(1, 150);
                    else
                        tmo = $urandom();
                    tag = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
                    issue_request(OP_CREATE, $urandom(), tmo, tag);
                end
                else if (pct < create_pct + 30)
                begin
                    // mostly live ids; the rest are misses, near or far
                    if (live_ids.size() != 0 && $urandom_range(0, 4) != 0)
                    begin
                        k  = $urandom_range(0, live_ids.size() - 1);
                        id = live_ids[k];
                        live_ids.delete(k);
                    end
                    else if ($urandom_range(0, 1) != 0)
                    begin
                        id = $urandom();
                    end
                    else
                    begin
                        id = $urandom_range(0, 800);
                    end
                    tag = ($urandom_range(0, 2) == 0) ? '0 : $urandom();
                    issue_request(pct[0] ? OP_COMPLETE : OP_CANCEL, id, $urandom(), tag);
                end
                else
                begin
                    issue_request(OP_EXPIRE, $urandom(), $urandom(), $urandom());
                end
            end
        end

        // final scan at the top of time clears every entry with a deadline
        tick_now = '1;
        no_idle  = 1'b0;
        issue_request(OP_EXPIRE, '0, '0, '0);
        req_ch.valid <= 1'b0;

        // drain: wait for every due response, then watch for strays
        @(negedge clk);
        while (pending_rsp != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run: %0d requests over %0d time epochs up to the top of the tick range,",
                 sent_count, RAND_EPOCHS);
        $display("     %0d responses checked, %0d timeouts, %0d table-full refusals.",
                 rsp_checked, timeouts_seen, full_seen);
        if (fail_count == 0 && pending_rsp == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
